FILE: hdl/pearson_correlation_unit_defines.svh
// Assertion macros for the Pearson correlation unit checker.
// Used by the checker file only; no other dependencies.
`ifndef PEARSON_CORRELATION_UNIT_DEFINES_SVH
`define PEARSON_CORRELATION_UNIT_DEFINES_SVH

// Clocked assertion that is ignored while reset is asserted.
`define PCU_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PCU_ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/pcu_pkg.sv
// Shared types and constants of the Pearson correlation unit.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps
`default_nettype none

package pcu_pkg;

	// Fixed result format: Q2.14, one quotient bit more for rounding.
	localparam int QUOT_BITS = 16;
	localparam logic [15:0] ONE_Q14 = 16'd16384;

	typedef struct packed {
		logic signed [15:0] sample_a;
		logic signed [15:0] sample_b;
		logic               last_pair;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] correlation;
		logic               defined;
		logic [12:0]        pair_count;
	} result_t;

	// Which moment a product step works on.
	typedef enum logic [1:0] {
		SEL_CROSS,
		SEL_FIRST,
		SEL_SECOND
	} mom_sel_t;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_PROD,
		ST_DIFF,
		ST_MUL_INIT,
		ST_MUL,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_DIV_INIT,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic     acc_en;
		logic     clear;
		mom_sel_t sel;
		logic     prod_en;
		logic     diff_en;
		logic     mul_init;
		logic     mul_step;
		logic     root_init;
		logic     root_step;
		logic     div_init;
		logic     div_step;
		logic     div_first;
		logic     load_out;
	} cmd_t;

endpackage

`default_nettype wire

FILE: hdl/pearson_correlation_unit.sv
// Pearson correlation unit: takes one sample pair per cycle and, after the
// pair marked last, produces the correlation coefficient in Q2.14. Pairs are
// accepted one per cycle while accumulating, also while a previous result
// still waits at the output. After the last pair the unit stalls its input
// while it forms the products and differences and runs the bit-serial
// multiplier, square root and divider, and while a previous result still
// waits at the output. A series longer than MAX_LENGTH or with zero
// variance gives a result with defined low and a coefficient of zero.
// Depends on pcu_pkg, pcu_controller and pcu_datapath.
`timescale 1ns / 1ps
`default_nettype none

module pearson_correlation_unit import pcu_pkg::*; #(
	parameter int MAX_LENGTH   = 4096,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    sample_valid,
	output logic         sample_stall,
	input  wire sample_t sample,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	cmd_t cmd;

	// Sequencer.
	pcu_controller #(
		.MAX_LENGTH  (MAX_LENGTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.last_pair   (sample.last_pair),
		.result_stall(result_stall),
		.sample_stall(sample_stall),
		.result_valid(result_valid),
		.cmd         (cmd)
	);

	// Arithmetic.
	pcu_datapath #(
		.MAX_LENGTH  (MAX_LENGTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample),
		.cmd   (cmd),
		.result(result)
	);

endmodule

`default_nettype wire

FILE: hdl/pcu_datapath.sv
// Datapath of the Pearson correlation unit: moment accumulators, product and
// difference stage, shift-add multiplier, square root and divider.
// Depends on pcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcu_datapath import pcu_pkg::*; #(
	parameter int MAX_LENGTH   = 4096,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire sample_t sample,
	input  wire cmd_t    cmd,
	output result_t      result
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CW  = $clog2(MAX_LENGTH + 1);
	localparam int S1W = SW + CW;
	localparam int S2W = 2 * SW + CW - 1;
	localparam int PNW = CW + 1 + S2W;
	localparam int PSW = 2 * S1W;
	localparam int VW  = (PNW > PSW) ? PNW : PSW;

	logic [31:0]             a_wide, b_wide;
	logic signed [SW-1:0]    a_ext, b_ext;
	logic signed [2*SW-1:0]  p_ab, p_aa, p_bb;
	logic                    full;

	logic [CW-1:0]           cnt_q;
	logic                    ovf_q;
	logic signed [S1W-1:0]   sa_q, sb_q;
	logic signed [S2W-1:0]   sab_q, saa_q, sbb_q;

	logic signed [CW:0]      n_s;
	logic signed [S2W-1:0]   sel_sum;
	logic signed [S1W-1:0]   sel_x, sel_y;
	logic signed [PNW-1:0]   pn;
	logic signed [PSW-1:0]   ps;
	logic signed [VW-1:0]    prod_n_s1, prod_s_s1, diff;
	logic signed [VW-1:0]    num_q, va_q, vb_q;

	logic [VW-1:0]           mplier_q;
	logic [2*VW-1:0]         macc_q;

	logic [2*VW-1:0]         p_q;
	logic [VW+1:0]           rem_q, rem_sh, trial;
	logic [VW-1:0]           root_q;
	logic                    root_ge;

	logic [VW-1:0]           mag;
	logic [VW:0]             r_q, r_sh;
	logic                    div_ge;
	logic [QUOT_BITS-1:0]    q_q;

	logic [QUOT_BITS:0]      q_round;
	logic [15:0]             q_mag;
	logic                    def;
	result_t                 result_q;

	// Sample extension to the configured width.
	assign a_wide = {16'b0, sample.sample_a};
	assign b_wide = {16'b0, sample.sample_b};
	assign a_ext  = $signed(a_wide[SW-1:0]);
	assign b_ext  = $signed(b_wide[SW-1:0]);
	assign p_ab   = a_ext * b_ext;
	assign p_aa   = a_ext * a_ext;
	assign p_bb   = b_ext * b_ext;
	assign full   = (cnt_q == CW'(MAX_LENGTH));

	// Running moments; a pair past the length limit only flags overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			sa_q  <= '0;
			sb_q  <= '0;
			sab_q <= '0;
			saa_q <= '0;
			sbb_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			sa_q  <= '0;
			sb_q  <= '0;
			sab_q <= '0;
			saa_q <= '0;
			sbb_q <= '0;
		end else if (cmd.acc_en) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CW'(1);
				sa_q  <= sa_q + S1W'(a_ext);
				sb_q  <= sb_q + S1W'(b_ext);
				sab_q <= sab_q + S2W'(p_ab);
				saa_q <= saa_q + S2W'(p_aa);
				sbb_q <= sbb_q + S2W'(p_bb);
			end
		end
	end

	// Operand selection for the product step.
	always_comb begin
		case (cmd.sel)
			SEL_CROSS: begin
				sel_sum = sab_q;
				sel_x   = sa_q;
				sel_y   = sb_q;
			end
			SEL_FIRST: begin
				sel_sum = saa_q;
				sel_x   = sa_q;
				sel_y   = sa_q;
			end
			default: begin
				sel_sum = sbb_q;
				sel_x   = sb_q;
				sel_y   = sb_q;
			end
		endcase
	end

	assign n_s  = $signed({1'b0, cnt_q});
	assign pn   = n_s * sel_sum;
	assign ps   = sel_x * sel_y;
	assign diff = prod_n_s1 - prod_s_s1;

	// Products n*S and S*S, then their difference.
	always_ff @(posedge clk) begin
		if (cmd.prod_en) begin
			prod_n_s1 <= VW'(pn);
			prod_s_s1 <= VW'(ps);
		end
		if (cmd.diff_en) begin
			case (cmd.sel)
				SEL_CROSS: num_q <= diff;
				SEL_FIRST: va_q  <= diff;
				default:   vb_q  <= diff;
			endcase
		end
	end

	// Shift-add multiplier forming Va*Vb, one multiplier bit per cycle.
	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			mplier_q <= va_q;
			macc_q   <= '0;
		end else if (cmd.mul_step) begin
			mplier_q <= {mplier_q[VW-2:0], 1'b0};
			macc_q   <= {macc_q[2*VW-2:0], 1'b0}
				+ (mplier_q[VW-1] ? {{VW{1'b0}}, vb_q} : '0);
		end
	end

	// Restoring square root, one root bit per cycle.
	assign rem_sh  = {rem_q[VW-1:0], p_q[2*VW-1:2*VW-2]};
	assign trial   = {root_q, 2'b01};
	assign root_ge = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			p_q    <= macc_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			p_q    <= {p_q[2*VW-3:0], 2'b00};
			rem_q  <= root_ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[VW-2:0], root_ge};
		end
	end

	// Restoring divider for |N| * 2^15 / root, one quotient bit per cycle.
	assign mag    = num_q[VW-1] ? VW'(-num_q) : VW'(num_q);
	assign r_sh   = cmd.div_first ? r_q : {r_q[VW-1:0], 1'b0};
	assign div_ge = (r_sh >= {1'b0, root_q});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			r_q <= (mag > root_q) ? {1'b0, root_q} : {1'b0, mag};
			q_q <= '0;
		end else if (cmd.div_step) begin
			r_q <= div_ge ? (r_sh - {1'b0, root_q}) : r_sh;
			q_q <= {q_q[QUOT_BITS-2:0], div_ge};
		end
	end

	// Rounding to nearest, clamp, sign and the undefined cases.
	assign q_round = ({1'b0, q_q} + (QUOT_BITS + 1)'(1)) >> 1;
	assign q_mag   = (q_round > {1'b0, ONE_Q14}) ? ONE_Q14 : q_round[15:0];
	assign def     = !ovf_q && !va_q[VW-1] && (va_q != '0)
		&& !vb_q[VW-1] && (vb_q != '0);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.defined    <= def;
			result_q.pair_count <= 13'(cnt_q);
			if (!def) begin
				result_q.correlation <= '0;
			end else if (num_q[VW-1]) begin
				result_q.correlation <= -$signed(q_mag);
			end else begin
				result_q.correlation <= $signed(q_mag);
			end
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

FILE: hdl/pcu_controller.sv
// Controller of the Pearson correlation unit: sequences accumulation and the
// end-of-series computation, and owns the result valid flag.
// Depends on pcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcu_controller import pcu_pkg::*; #(
	parameter int MAX_LENGTH   = 4096,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic sample_valid,
	input  wire logic last_pair,
	input  wire logic result_stall,
	output logic      sample_stall,
	output logic      result_valid,
	output cmd_t      cmd
);

	localparam int CW   = $clog2(MAX_LENGTH + 1);
	localparam int S1W  = SAMPLE_WIDTH + CW;
	localparam int S2W  = 2 * SAMPLE_WIDTH + CW - 1;
	localparam int PNW  = CW + 1 + S2W;
	localparam int PSW  = 2 * S1W;
	localparam int VW   = (PNW > PSW) ? PNW : PSW;
	localparam int CNTW = $clog2(VW);

	state_t          state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	logic            valid_q, valid_d;

	// State, step counter and result valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			valid_q <= valid_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		valid_d = valid_q && result_stall;
		cmd     = '0;
		case (cnt_q[1:0])
			2'd0:    cmd.sel = SEL_CROSS;
			2'd1:    cmd.sel = SEL_FIRST;
			default: cmd.sel = SEL_SECOND;
		endcase
		case (state_q)
			ST_ACC: begin
				cmd.acc_en = sample_valid;
				if (sample_valid && last_pair) begin
					state_d = ST_PROD;
					cnt_d   = '0;
				end
			end
			ST_PROD: begin
				cmd.prod_en = 1'b1;
				state_d     = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff_en = 1'b1;
				if (cnt_q == CNTW'(2)) begin
					state_d = ST_MUL_INIT;
					cnt_d   = '0;
				end else begin
					state_d = ST_PROD;
					cnt_d   = cnt_q + CNTW'(1);
				end
			end
			ST_MUL_INIT: begin
				cmd.mul_init = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == CNTW'(VW - 1)) begin
					state_d = ST_ROOT_INIT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + CNTW'(1);
				end
			end
			ST_ROOT_INIT: begin
				cmd.root_init = 1'b1;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == CNTW'(VW - 1)) begin
					state_d = ST_DIV_INIT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + CNTW'(1);
				end
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				if (cnt_q == CNTW'(QUOT_BITS - 1)) begin
					state_d = ST_EMIT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + CNTW'(1);
				end
			end
			ST_EMIT: begin
				// Wait until the output register is free, then load it.
				if (!valid_q || !result_stall) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					valid_d      = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

	assign sample_stall = (state_q != ST_ACC);
	assign result_valid = valid_q;

endmodule

`default_nettype wire

FILE: hdl/pcu_checker.sv
// Port-level checker for the Pearson correlation unit, bound to the top level.
// Depends on pcu_pkg and pearson_correlation_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "pearson_correlation_unit_defines.svh"

module pcu_checker import pcu_pkg::*; #(
	parameter int MAX_LENGTH = 4096
) (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// A waiting result stays offered.
	`PCU_ASSERT(a_result_held, result_valid && result_stall |=> result_valid, "result dropped")

	// The coefficient never leaves the range -1 to +1.
	`PCU_ASSERT(a_corr_range, result_valid |-> (result.correlation >= -16'sd16384) && (result.correlation <= 16'sd16384), "correlation out of range")

	// An undefined result carries a zero coefficient.
	`PCU_ASSERT(a_undef_zero, result_valid && !result.defined |-> result.correlation == '0, "undefined result not zero")

	// The reported count never exceeds the length limit.
	`PCU_ASSERT(a_count_max, result_valid |-> 32'(result.pair_count) <= 32'(MAX_LENGTH), "pair count too large")

	// No result is offered during reset.
	`PCU_ASSERT_RST(a_reset_quiet, !arst_n |-> !result_valid, "result valid in reset")

endmodule

bind pearson_correlation_unit pcu_checker #(.MAX_LENGTH(MAX_LENGTH)) u_pcu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);

`default_nettype wire
